@@ design/lgrs_pkg.sv @@
// shared types and constants for the life generation row stencil
package lgrs_pkg;

    localparam int DATA_W    = 64;  // width of a row on the stream ports
    localparam int CNT_W     = 11;  // rows register and row counter width
    localparam int COLS_W    = 7;   // cols register width
    localparam int IDX_W     = 10;  // result row index width
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 8'd0,
        CFG_COLS = 8'd1
    } t_cfg_idx;

endpackage

@@ design/lgrs_stencil.sv @@
// b3/s23 next-state logic for one row from its upper and lower neighbor rows
module lgrs_stencil #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] i_up,
    input  logic [WIDTH-1:0] i_mid,
    input  logic [WIDTH-1:0] i_down,
    output logic [WIDTH-1:0] o_next
);
    import lgrs_pkg::*;

    // zero cells padded on both sides so edge columns see dead neighbors
    logic [WIDTH+1:0] w_up;
    logic [WIDTH+1:0] w_mid;
    logic [WIDTH+1:0] w_down;

    assign w_up   = {1'b0, i_up,   1'b0};
    assign w_mid  = {1'b0, i_mid,  1'b0};
    assign w_down = {1'b0, i_down, 1'b0};

    for (genvar c = 0; c < WIDTH; c++) begin : g_col
        logic [3:0] w_cnt;
        assign w_cnt = 4'(w_up[c]) + 4'(w_up[c+1]) + 4'(w_up[c+2])
                     + 4'(w_mid[c]) + 4'(w_mid[c+2])
                     + 4'(w_down[c]) + 4'(w_down[c+1]) + 4'(w_down[c+2]);
        assign o_next[c] = (w_cnt == 4'd3) || ((w_cnt == 4'd2) && i_mid[c]);
    end

endmodule

@@ design/life_generation_row_stencil.sv @@
// top level: one b3/s23 generation over a grid streamed one row per item
//
// usage
//   - s_axis carries one grid row per item, bit k of tdata is column k (1 alive);
//     bits at and above the cols setting are ignored
//   - m_axis carries result rows: tdata holds the next-generation row and its
//     grid row index, tlast marks the last row of the frame
//   - the cfg channel writes rows (index 0) and cols (index 1); it is always
//     ready and a write lands at once, other indexes are dropped
//   - the result for row r leaves after row r+1 is taken; the last row of a
//     frame releases two results, the row before it and itself; a one-row
//     frame gives one result; the first row of a longer frame gives none
//   - a row is registered in the input stage, then its result in the output register
//   - throughput: one row per cycle while m_axis is not stalled; the last row of a
//     frame holds the input stage while its two results drain through the single
//     stencil unit
//   - a stalled m_axis holds the output register; s_axis_tready drops once a row
//     that gives a result waits in the input stage
//   - reset: rows and cols return to 64, held rows and the row counter clear,
//     both stages empty
module life_generation_row_stencil #(
    parameter int ROW_WIDTH = 64,
    parameter int MAX_ROWS  = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input rows
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lgrs_pkg::DATA_W-1:0]          s_axis_tdata,   // cur_row
    // result rows
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lgrs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // next_row, row_index, zero pad
    output logic                                 m_axis_tlast,   // frame_done
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lgrs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lgrs_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import lgrs_pkg::*;

    // rows clamp, capped at what the row counter can hold
    localparam int RowsCap = (MAX_ROWS > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_ROWS;
    localparam logic [CNT_W-1:0]  RowsCapL = CNT_W'(RowsCap);
    localparam logic [COLS_W-1:0] ColsCapL = COLS_W'(ROW_WIDTH);

    // configuration registers
    logic [CNT_W-1:0]  r_rows;
    logic [COLS_W-1:0] r_cols;

    // frame state
    logic [ROW_WIDTH-1:0] r_held0;  // row r-1
    logic [ROW_WIDTH-1:0] r_held1;  // row r-2
    logic [CNT_W-1:0]     r_rows_seen;

    // input stage: one accepted row with its neighbors
    logic                 r_s1_valid;
    logic                 r_s1_phase;   // first result already sent
    logic                 r_s1_has_a;   // result for the row above exists
    logic                 r_s1_last;    // also emit the current row itself
    logic [CNT_W-1:0]     r_s1_k;
    logic [ROW_WIDTH-1:0] r_s1_up;
    logic [ROW_WIDTH-1:0] r_s1_mid;
    logic [ROW_WIDTH-1:0] r_s1_cur;

    // output register
    logic                 r_o_valid;
    logic [ROW_WIDTH-1:0] r_o_row;
    logic [IDX_W-1:0]     r_o_idx;
    logic                 r_o_last;

    logic [CNT_W-1:0]     w_eff_rows;
    logic [COLS_W-1:0]    w_eff_cols;
    logic [ROW_WIDTH-1:0] w_mask;
    logic [ROW_WIDTH-1:0] w_cur;
    logic                 w_accept;
    logic                 w_in_last;
    logic                 w_in_has_a;
    logic                 w_sel_b;
    logic                 w_final;
    logic                 w_out_load;
    logic                 w_s1_done;
    logic [ROW_WIDTH-1:0] w_st_up;
    logic [ROW_WIDTH-1:0] w_st_mid;
    logic [ROW_WIDTH-1:0] w_st_down;
    logic [ROW_WIDTH-1:0] w_st_next;
    logic [CNT_W-1:0]     w_res_k;

    // effective settings, zero acts as one and values past the cap clamp
    always_comb begin
        w_eff_rows = r_rows;
        if (w_eff_rows == '0) w_eff_rows = CNT_W'(1);
        if (w_eff_rows > RowsCapL) w_eff_rows = RowsCapL;
        w_eff_cols = r_cols;
        if (w_eff_cols == '0) w_eff_cols = COLS_W'(1);
        if (w_eff_cols > ColsCapL) w_eff_cols = ColsCapL;
    end

    for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_mask
        assign w_mask[c] = COLS_W'(c) < w_eff_cols;
    end

    assign w_cur      = s_axis_tdata[ROW_WIDTH-1:0] & w_mask;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_in_has_a = (r_rows_seen != '0);
    assign w_in_last  = ({1'b0, r_rows_seen} + (CNT_W+1)'(1)) >= {1'b0, w_eff_rows};

    // the input stage emits the row-above result first, then, on a frame's last row, its own row
    assign w_sel_b    = !r_s1_has_a || r_s1_phase;
    assign w_final    = w_sel_b || !r_s1_last;
    assign w_out_load = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign w_s1_done  = w_out_load && w_final;

    assign s_axis_tready = !r_s1_valid || w_s1_done;
    assign o_cfg_ready   = 1'b1;

    // held rows are masked again in case cols shrank since they were stored
    assign w_st_up   = (w_sel_b ? r_s1_mid : r_s1_up) & w_mask;
    assign w_st_mid  = (w_sel_b ? r_s1_cur : r_s1_mid) & w_mask;
    assign w_st_down = w_sel_b ? '0 : r_s1_cur;
    assign w_res_k   = w_sel_b ? r_s1_k : (r_s1_k - CNT_W'(1));

    lgrs_stencil #(
        .WIDTH (ROW_WIDTH)
    ) u_stencil (
        .i_up   (w_st_up),
        .i_mid  (w_st_mid),
        .i_down (w_st_down),
        .o_next (w_st_next)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CNT_W'(64);
            r_cols <= COLS_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS: r_rows <= i_cfg_data[CNT_W-1:0];
                CFG_COLS: r_cols <= i_cfg_data[COLS_W-1:0];
                default:  ;
            endcase
        end
    end

    // frame state: shift held rows, clear on the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0     <= '0;
            r_held1     <= '0;
            r_rows_seen <= '0;
        end else if (w_accept) begin
            if (w_in_last) begin
                r_held0     <= '0;
                r_held1     <= '0;
                r_rows_seen <= '0;
            end else begin
                r_held1     <= r_held0;
                r_held0     <= w_cur;
                r_rows_seen <= r_rows_seen + CNT_W'(1);
            end
        end
    end

    // input stage; rows that give no result never occupy it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_in_has_a || w_in_last;
            r_s1_phase <= 1'b0;
        end else if (w_s1_done) begin
            r_s1_valid <= 1'b0;
            r_s1_phase <= 1'b0;
        end else if (w_out_load) begin
            r_s1_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_has_a <= w_in_has_a;
            r_s1_last  <= w_in_last;
            r_s1_k     <= r_rows_seen;
            r_s1_up    <= r_held1;
            r_s1_mid   <= r_held0;
            r_s1_cur   <= w_cur;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_row  <= w_st_next & w_mask;
            r_o_idx  <= w_res_k[IDX_W-1:0];
            r_o_last <= w_sel_b;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {(OUT_TDATA_W - DATA_W - IDX_W)'(0), r_o_idx,
                            DATA_W'(r_o_row)};

endmodule

@@ tb/life_generation_row_stencil_tb.sv @@
// testbench for life_generation_row_stencil: one-generation grid stencil checked against a predictor
`timescale 1ns / 100ps

module life_generation_row_stencil_tb;

    import lgrs_pkg::*;

    localparam int ROW_W        = 64;
    localparam int GRID_ROWS    = 1024;
    localparam int NUM_REGS     = 2;    // registers in the map, higher indexes are dropped
    localparam int RANDOM_ITEMS = 80;   // the full-height frame at the end adds GRID_ROWS more
    localparam int SETTLE       = 4;    // cycles that cover the two-stage latency
    localparam int HOLD_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] TOP_IDX = {CFG_IDX_W{1'b1}};

    // one expected result row
    typedef struct packed {
        logic [DATA_W-1:0] next_row;
        logic [IDX_W-1:0]  row_index;
        logic              frame_done;
    } t_life_row;

    typedef enum int {
        MIX_RANDOM,
        MIX_SPARSE,
        MIX_DENSE,
        MIX_EMPTY,
        MIX_FULL
    } t_row_mix;

    // predictor and store of expected result rows
    class life_tracker;
        logic [CNT_W-1:0]  rows_reg;
        logic [COLS_W-1:0] cols_reg;
        logic [DATA_W-1:0] prev_row;     // row r-1
        logic [DATA_W-1:0] prev2_row;    // row r-2
        logic [CNT_W-1:0]  rows_seen;
        t_life_row         expected_rows[$];
        int                mismatches;

        function new();
            rows_reg   = 11'd64;
            cols_reg   = 7'd64;
            prev_row   = '0;
            prev2_row  = '0;
            rows_seen  = '0;
            mismatches = 0;
        endfunction

        function int eff_cols();
            int c;
            c = cols_reg;
            if (c < 1) c = 1;
            if (c > ROW_W) c = ROW_W;
            return c;
        endfunction

        function int eff_rows();
            int r;
            r = rows_reg;
            if (r < 1) r = 1;
            if (r > GRID_ROWS) r = GRID_ROWS;
            return r;
        endfunction

        function logic [DATA_W-1:0] col_mask(input int w);
            if (w >= DATA_W) return '1;
            return (64'd1 << w) - 64'd1;
        endfunction

        // cells outside the used columns count as dead
        function int cell_at(input logic [DATA_W-1:0] v, input int c, input int w);
            if (c < 0 || c >= w) return 0;
            return int'(v[c]);
        endfunction

        // b3/s23 rule over three rows, mid being the row that evolves
        function logic [DATA_W-1:0] evolve_row(input logic [DATA_W-1:0] up,
                                               input logic [DATA_W-1:0] mid,
                                               input logic [DATA_W-1:0] dn,
                                               input int w);
            logic [DATA_W-1:0] res;
            int c;
            int n;
            res = '0;
            for (c = 0; c < w; c++) begin
                n = cell_at(up, c - 1, w) + cell_at(up, c, w) + cell_at(up, c + 1, w)
                  + cell_at(mid, c - 1, w) + cell_at(mid, c + 1, w)
                  + cell_at(dn, c - 1, w) + cell_at(dn, c, w) + cell_at(dn, c + 1, w);
                if (n == 3 || (n == 2 && cell_at(mid, c, w) == 1)) res[c] = 1'b1;
            end
            return res;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_ROWS) rows_reg = data[CNT_W-1:0];
            else if (idx == CFG_COLS) cols_reg = data[COLS_W-1:0];
        endfunction

        function int frame_pos();
            return int'(rows_seen);
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        // an input row was accepted
        function void take_row(input logic [DATA_W-1:0] row_in);
            int w;
            logic [DATA_W-1:0] mask;
            logic [DATA_W-1:0] cur;
            logic [CNT_W-1:0]  k1;
            logic              last;
            t_life_row         e;
            w    = eff_cols();
            mask = col_mask(w);
            cur  = row_in & mask;
            last = (int'(rows_seen) + 1 >= eff_rows());
            if (rows_seen >= 1) begin
                k1           = rows_seen - 11'd1;
                e.next_row   = evolve_row(prev2_row, prev_row, cur, w) & mask;
                e.row_index  = k1[IDX_W-1:0];
                e.frame_done = 1'b0;
                expected_rows.push_back(e);
            end
            if (last) begin
                // the last row also flushes itself, with a dead row below
                e.next_row   = evolve_row((rows_seen >= 1) ? prev_row : '0, cur, '0, w) & mask;
                e.row_index  = rows_seen[IDX_W-1:0];
                e.frame_done = 1'b1;
                expected_rows.push_back(e);
                prev_row  = '0;
                prev2_row = '0;
                rows_seen = '0;
            end else begin
                prev2_row = prev_row;
                prev_row  = cur;
                rows_seen = rows_seen + 11'd1;
            end
        endfunction

        // a result row was accepted
        function void match_result(input logic [OUT_TDATA_W-1:0] tdata, input logic tlast);
            t_life_row e;
            if (expected_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result row %h index %0d last %b",
                             tdata[DATA_W-1:0], tdata[DATA_W +: IDX_W], tlast);
                return;
            end
            e = expected_rows.pop_front();
            if (tdata[DATA_W-1:0] !== e.next_row || tdata[DATA_W +: IDX_W] !== e.row_index
                || tlast !== e.frame_done || tdata[OUT_TDATA_W-1:DATA_W+IDX_W] !== '0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"row mismatch: expected %h idx %0d last %b,",
                              " got %h idx %0d last %b pad %h"},
                             e.next_row, e.row_index, e.frame_done,
                             tdata[DATA_W-1:0], tdata[DATA_W +: IDX_W], tlast,
                             tdata[OUT_TDATA_W-1:DATA_W+IDX_W]);
            end
        endfunction

        function void close_out();
            if (expected_rows.size() > 0) begin
                mismatches += expected_rows.size();
                $display("%0d result rows never arrived", expected_rows.size());
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata;     // cur_row
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;     // next_row, row_index, zero pad
    logic                   m_axis_tlast;     // frame_done
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DAT_W-1:0]   i_cfg_data;

    life_tracker tracker;
    bit          no_gaps;        // both sides run without idling while set
    int          hold_request;   // long receiver hold-off, picked up by the result sink
    int          rows_sent;

    life_generation_row_stencil #(
        .ROW_WIDTH (ROW_W),
        .MAX_ROWS  (GRID_ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // offer one row after a random gap, return at the edge that takes it
    task automatic send_row(input logic [DATA_W-1:0] row);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_row(row);
        rows_sent++;
    endtask

    // stop offering rows, wait for every expected result, then let the pipe settle
    task automatic rest();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // only called while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] make_row(input t_row_mix mix);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (mix)
            MIX_SPARSE: r = a & b;
            MIX_DENSE:  r = a | b;
            MIX_EMPTY:  r = '0;
            MIX_FULL:   r = '1;
            default:    r = a;
        endcase
        return r;
    endfunction

    // rows value in the low bits, junk above the register width
    function automatic logic [CFG_DAT_W-1:0] rows_word(input int r);
        logic [CFG_DAT_W-1:0] w;
        w = CFG_DAT_W'($urandom);
        w[CNT_W-1:0] = CNT_W'(r);
        return w;
    endfunction

    // cols value, weighted toward the out-of-range and narrow ends
    function automatic logic [CFG_DAT_W-1:0] cols_word();
        logic [CFG_DAT_W-1:0] w;
        int pick;
        w = CFG_DAT_W'($urandom);
        case ($urandom_range(0, 9))
            0:       pick = 0;
            1:       pick = ROW_W;
            2:       pick = $urandom_range(ROW_W + 1, (1 << COLS_W) - 1);
            3:       pick = $urandom_range(1, 3);
            default: pick = $urandom_range(1, ROW_W);
        endcase
        w[COLS_W-1:0] = COLS_W'(pick);
        return w;
    endfunction

    // send rows until the current frame closes
    task automatic run_frame();
        t_row_mix mix;
        mix = t_row_mix'($urandom_range(0, 4));
        do begin
            if ($urandom_range(0, 7) == 0) send_row(make_row(t_row_mix'($urandom_range(0, 4))));
            else send_row(make_row(mix));
        end while (tracker.frame_pos() != 0);
    endtask

    // result sink: checks every accepted result and idles at random
    initial begin : result_sink
        int wait_left;
        int hold_left;
        wait_left     = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.match_result(m_axis_tdata, m_axis_tlast);
                wait_left = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // stimulus: directed corner cases, random phases, then one full-height frame
    initial begin : stimulus
        int base;
        int mode;
        int n;
        tracker       = new();
        no_gaps       = 1'b0;
        hold_request  = 0;
        rows_sent     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two-row frame with cols still at its reset value
        cfg_write(CFG_ROWS, 16'd2);
        send_row('1);
        send_row('1);
        rest();

        // single-row frames: both neighbor rows dead
        cfg_write(CFG_ROWS, 16'd1);
        send_row('1);
        send_row(64'h8000_0000_0000_0001);
        send_row('0);
        rest();

        // blinker in the middle, then blocks at both edge columns
        cfg_write(CFG_ROWS, 16'd3);
        send_row('0);
        send_row(64'h0000_0007_0000_0000);
        send_row('0);
        repeat (3) send_row(64'hC000_0000_0000_0003);
        rest();

        // narrow grid, bits above cols must be ignored
        cfg_write(CFG_COLS, 16'd3);
        repeat (3) send_row('1);
        rest();

        // zero settings act as one, an unknown index is dropped
        cfg_write(CFG_COLS, 16'd0);
        cfg_write(CFG_ROWS, 16'd0);
        cfg_write(TOP_IDX, 16'hFFFF);
        send_row('1);
        rest();

        // cols above the row width clamps to full width
        cfg_write(CFG_COLS, 16'hFFFF);
        cfg_write(CFG_ROWS, 16'd2);
        send_row('1);
        send_row(64'h5555_5555_5555_5555);
        rest();

        // rows shrunk below the count already seen closes the frame on the next row
        cfg_write(CFG_ROWS, 16'd10);
        repeat (3) send_row(make_row(MIX_RANDOM));
        rest();
        cfg_write(CFG_ROWS, 16'd2);
        send_row(make_row(MIX_RANDOM));
        rest();

        // receiver holds off while rows keep coming, so the input stalls
        no_gaps = 1'b1;
        cfg_write(CFG_ROWS, rows_word(12));
        hold_request = HOLD_CYCLES;
        run_frame();
        rest();

        base = rows_sent;
        while (rows_sent - base < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            mode    = $urandom_range(0, 5);
            if (mode == 0) begin
                // tall frame cut short mid-way
                cfg_write(CFG_ROWS, rows_word($urandom_range(100, (1 << CNT_W) - 1)));
                if ($urandom_range(0, 1)) cfg_write(CFG_COLS, cols_word());
                n = $urandom_range(1, 4);
                repeat (n) send_row(make_row(t_row_mix'($urandom_range(0, 4))));
                rest();
                cfg_write(CFG_ROWS, rows_word($urandom_range(0, n)));
                if ($urandom_range(0, 1)) cfg_write(CFG_COLS, cols_word());
                run_frame();
            end else begin
                if ($urandom_range(0, 1)) cfg_write(CFG_COLS, cols_word());
                if ($urandom_range(0, 2) != 0)
                    cfg_write(CFG_ROWS, rows_word((mode == 1) ? $urandom_range(9, 40)
                                                              : $urandom_range(0, 8)));
                if ($urandom_range(0, 7) == 0)
                    cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, TOP_IDX)), CFG_DAT_W'($urandom));
                repeat ($urandom_range(1, 4)) run_frame();
            end
            rest();
        end

        // full-height frame reaches the top row index
        no_gaps = 1'b0;
        cfg_write(CFG_ROWS, 16'hFFFF);
        cfg_write(CFG_COLS, cols_word());
        run_frame();
        rest();

        repeat (SETTLE * 4) @(posedge i_clk);
        tracker.close_out();
        if (tracker.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ life_generation_row_stencil.f @@
design/lgrs_pkg.sv
design/lgrs_stencil.sv
design/life_generation_row_stencil.sv
tb/life_generation_row_stencil_tb.sv
